/* design/spfd_pkg.sv */
// ----------------------------------------------------------------------------
// spfd_pkg
// Types and constants shared by the sensor pulse frame decoder.
// ----------------------------------------------------------------------------
package spfd_pkg;

   localparam logic       OP_BEGIN        = 1'b0;
   localparam logic       OP_EDGE         = 1'b1;
   localparam logic [5:0] FRAME_EDGES     = 6'd41;
   localparam logic [15:0] THRESHOLD_RESET = 16'd100;
   localparam int         FRAME_BITS      = 40;
   // widest timer supported, used for the interval compare
   localparam int         CMP_WIDTH       = 32;

   typedef logic [15:0] threshold_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] timestamp;
   } req_type;

   typedef struct packed {
      logic        checksum_ok;
      logic [7:0]  humidity_integral;
      logic [7:0]  humidity_decimal;
      logic [7:0]  temperature_integral;
      logic [7:0]  temperature_decimal;
      logic [7:0]  checksum_byte;
      logic [11:0] humidity_tenths;
      logic [11:0] temperature_tenths;
   } rsp_type;

   // decoded frame, from the frame calculator to the top level
   typedef struct packed {
      logic        checksum_ok;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  byte4;
      logic [11:0] humidity;
      logic [11:0] temperature;
   } frame_result_type;

endpackage

/* design/spfd_chan_if.sv */
// ----------------------------------------------------------------------------
// spfd_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface spfd_chan_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

/* design/spfd_frame_calc.sv */
// ----------------------------------------------------------------------------
// spfd_frame_calc
// Splits a 40-bit frame into bytes, checks the sum and forms tenths values.
// ----------------------------------------------------------------------------
module spfd_frame_calc (
   input  logic [spfd_pkg::FRAME_BITS-1:0] frame_bits,
   output spfd_pkg::frame_result_type      result
);
   import spfd_pkg::*;

   logic [7:0] sum_low;

   always_comb begin
      result.byte0 = frame_bits[39:32];
      result.byte1 = frame_bits[31:24];
      result.byte2 = frame_bits[23:16];
      result.byte3 = frame_bits[15:8];
      result.byte4 = frame_bits[7:0];
      sum_low = result.byte0 + result.byte1 + result.byte2 + result.byte3;
      result.checksum_ok = (sum_low == result.byte4);
      // x*10 = x*8 + x*2
      result.humidity = {1'b0, result.byte0, 3'b000} + {3'b000, result.byte0, 1'b0}
                        + {4'b0000, result.byte1};
      result.temperature = {1'b0, result.byte2, 3'b000} + {3'b000, result.byte2, 1'b0}
                           + {4'b0000, result.byte3};
   end

endmodule

/* design/sensor_pulse_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// sensor_pulse_frame_decoder_core
// Decodes a single-wire humidity/temperature sensor frame from edge times.
// ----------------------------------------------------------------------------
// Each request is either a begin (re-arm, clear the bit count) or a falling
// edge timestamp. After a begin, the first edge only sets the reference time;
// the next 41 stamps give intervals, modulo 2^STAMP_WIDTH. The first interval
// is the preamble and is dropped, the remaining 40 decode MSB first to five
// bytes (one when the interval exceeds the threshold). The 41st interval
// produces one response with the raw bytes, the checksum flag and humidity
// and temperature in tenths; the tenths values only move on a good checksum.
// Later edges are ignored until the next begin. Throughput is one request
// per clock while no unread response holds the input register; an accepted
// request waits in the input register, then passes through the decode logic
// into the response register. req.ready falls only while an unread response
// blocks a full input register. The threshold may be rewritten only while
// the block is idle; csr.ready is always high.
// ----------------------------------------------------------------------------
module sensor_pulse_frame_decoder_core #(
   parameter int STAMP_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   spfd_chan_if.sink   req,
   spfd_chan_if.source rsp,
   spfd_chan_if.sink   csr
);
   import spfd_pkg::*;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;

   // decode state
   logic                   armed_ff, armed_in;
   logic [STAMP_WIDTH-1:0] prev_stamp_ff, prev_stamp_in;
   logic [5:0]             edge_count_ff, edge_count_in;
   logic [FRAME_BITS-1:0]  frame_bits_ff, frame_bits_in;
   logic [11:0]            held_hum_ff, held_hum_in;
   logic [11:0]            held_temp_ff, held_temp_in;
   threshold_type          threshold_ff, threshold_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                   advance;
   logic                   emit;
   logic [STAMP_WIDTH-1:0] stamp;
   logic [STAMP_WIDTH-1:0] interval;
   logic                   bit_value;
   logic [5:0]             count_next;
   logic [FRAME_BITS-1:0]  shifted_bits;
   frame_result_type       calc;

   // input stage moves on when the response slot is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign csr.ready = 1'b1;

   // timer value truncated or zero-extended to STAMP_WIDTH
   assign stamp        = STAMP_WIDTH'(in_data_ff.timestamp);
   assign interval     = stamp - prev_stamp_ff;
   assign bit_value    = CMP_WIDTH'(interval) > CMP_WIDTH'(threshold_ff);
   assign count_next   = edge_count_ff + 6'd1;
   assign shifted_bits = {frame_bits_ff[FRAME_BITS-2:0], bit_value};

   spfd_frame_calc u_calc (
      .frame_bits (shifted_bits),
      .result     (calc)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_data_in    = in_data_ff;
      armed_in      = armed_ff;
      prev_stamp_in = prev_stamp_ff;
      edge_count_in = edge_count_ff;
      frame_bits_in = frame_bits_ff;
      held_hum_in   = held_hum_ff;
      held_temp_in  = held_temp_ff;
      threshold_in  = threshold_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      emit          = 1'b0;

      if (csr.valid) begin
         threshold_in = csr.payload;
      end

      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req.payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         if (in_data_ff.opcode == OP_BEGIN) begin
            edge_count_in = 6'd0;
            armed_in      = 1'b1;
            frame_bits_in = '0;
         end else if (edge_count_ff < FRAME_EDGES) begin
            if (armed_ff) begin
               // reference edge: time only
               armed_in      = 1'b0;
               prev_stamp_in = stamp;
            end else begin
               prev_stamp_in = stamp;
               edge_count_in = count_next;
               // preamble interval is dropped
               if (edge_count_ff != 6'd0) begin
                  frame_bits_in = shifted_bits;
               end
               if (count_next == FRAME_EDGES) begin
                  armed_in = 1'b1;
                  emit     = 1'b1;
               end
            end
         end
      end

      if (emit) begin
         if (calc.checksum_ok) begin
            held_hum_in  = calc.humidity;
            held_temp_in = calc.temperature;
         end
         rsp_valid_in                     = 1'b1;
         rsp_data_in.checksum_ok          = calc.checksum_ok;
         rsp_data_in.humidity_integral    = calc.byte0;
         rsp_data_in.humidity_decimal     = calc.byte1;
         rsp_data_in.temperature_integral = calc.byte2;
         rsp_data_in.temperature_decimal  = calc.byte3;
         rsp_data_in.checksum_byte        = calc.byte4;
         rsp_data_in.humidity_tenths      = held_hum_in;
         rsp_data_in.temperature_tenths   = held_temp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         armed_ff      <= 1'b1;
         prev_stamp_ff <= '0;
         edge_count_ff <= FRAME_EDGES;
         frame_bits_ff <= '0;
         held_hum_ff   <= '0;
         held_temp_ff  <= '0;
         threshold_ff  <= THRESHOLD_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         armed_ff      <= armed_in;
         prev_stamp_ff <= prev_stamp_in;
         edge_count_ff <= edge_count_in;
         frame_bits_ff <= frame_bits_in;
         held_hum_ff   <= held_hum_in;
         held_temp_ff  <= held_temp_in;
         threshold_ff  <= threshold_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // bit count never runs past a complete frame
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= FRAME_EDGES)
      else $error("edge count beyond frame length");

   // a fresh response only follows frame completion
   a_rsp_on_complete : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> edge_count_ff == FRAME_EDGES && armed_ff)
      else $error("response without completed frame");

   // a good frame reports tenths built from its own bytes
   a_good_tenths : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.checksum_ok |->
         rsp_data_ff.humidity_tenths ==
            12'(rsp_data_ff.humidity_integral) * 12'd10
            + 12'(rsp_data_ff.humidity_decimal)
         && rsp_data_ff.temperature_tenths ==
            12'(rsp_data_ff.temperature_integral) * 12'd10
            + 12'(rsp_data_ff.temperature_decimal))
      else $error("tenths disagree with good frame bytes");

endmodule
